FILE: rtl/fir_q15_pkg.sv
// ----------------------------------------------------------------------------
// fir_q15_pkg: shared types, constants and coefficient tables
// Holds the sizing constants of the Q15 FIR datapath, the control structs
// passed between its modules, the sequencer states and both coefficient ROMs.
// ----------------------------------------------------------------------------
package fir_q15_pkg;

   localparam int TAPS_DEFAULT = 40;
   localparam int SAMPLE_W     = 16;
   localparam int ACC_W        = 32;
   localparam int DIGIT_W      = 4;
   localparam int DIGITS       = SAMPLE_W / DIGIT_W;
   localparam int DIGIT_CNT_W  = $clog2(DIGITS);
   localparam int ROM_LEN      = 40;
   localparam int ROM_IDX_W    = $clog2(ROM_LEN);
   localparam int TAP_IDX_W    = 8;

   localparam logic signed [ACC_W-1:0] ACC_INIT = 32'sh0000_4000;
   localparam logic signed [ACC_W-1:0] RND_ADD  = 32'sh0000_8000;

   localparam logic FILTER_LOWPASS  = 1'b0;
   localparam logic FILTER_HIGHPASS = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_LOAD,
      ST_MUL,
      ST_ACC,
      ST_ROUND,
      ST_DONE
   } state_type;

   // Control of the digit-serial multiply-accumulate unit.
   typedef struct packed {
      logic init;   // load the accumulator with its starting value
      logic start;  // load coefficient and sample, clear the product
      logic step;   // consume one sample digit
      logic first;  // the digit of this step is the signed top digit
      logic accum;  // add the doubled product with saturation
      logic round;  // add the rounding constant with saturation
   } mac_ctrl_type;

   // Control of the delay line.
   typedef struct packed {
      logic write;    // store a new sample at the write index
      logic advance;  // move the write index on, wrapping at the tap count
   } dl_ctrl_type;

   localparam logic signed [SAMPLE_W-1:0] LOWPASS_ROM [ROM_LEN] = '{
      -16'sd61, -16'sd52, -16'sd64, -16'sd68, -16'sd58, -16'sd28, 16'sd29, 16'sd117,
      16'sd240, 16'sd400, 16'sd595, 16'sd820, 16'sd1069, 16'sd1330, 16'sd1591,
      16'sd1838, 16'sd2056, 16'sd2234, 16'sd2359, 16'sd2424, 16'sd2424, 16'sd2359,
      16'sd2234, 16'sd2056, 16'sd1838, 16'sd1591, 16'sd1330, 16'sd1069, 16'sd820,
      16'sd595, 16'sd400, 16'sd240, 16'sd117, 16'sd29, -16'sd28, -16'sd58, -16'sd68,
      -16'sd64, -16'sd52, -16'sd61
   };

   localparam logic signed [SAMPLE_W-1:0] HIGHPASS_ROM [ROM_LEN] = '{
      16'sd14, 16'sd29, 16'sd44, 16'sd45, 16'sd16, -16'sd53, -16'sd158, -16'sd273,
      -16'sd349, -16'sd324, -16'sd144, 16'sd207, 16'sd686, 16'sd1179, 16'sd1504,
      16'sd1434, 16'sd707, -16'sd1043, -16'sd4850, -16'sd20119, 16'sd20119,
      16'sd4850, 16'sd1043, -16'sd707, -16'sd1434, -16'sd1504, -16'sd1179,
      -16'sd686, -16'sd207, 16'sd144, 16'sd324, 16'sd349, 16'sd273, 16'sd158,
      16'sd53, -16'sd16, -16'sd45, -16'sd44, -16'sd29, -16'sd14
   };

   // Coefficient of one tap; taps past the end of the tables weigh zero.
   function automatic logic signed [SAMPLE_W-1:0] coef_at(
      input logic                 sel,
      input logic [TAP_IDX_W-1:0] idx
   );
      logic signed [SAMPLE_W-1:0] coef;
      coef = '0;
      if (idx < TAP_IDX_W'(ROM_LEN)) begin
         if (sel == FILTER_HIGHPASS) begin
            coef = HIGHPASS_ROM[idx[ROM_IDX_W-1:0]];
         end else begin
            coef = LOWPASS_ROM[idx[ROM_IDX_W-1:0]];
         end
      end
      return coef;
   endfunction

endpackage

FILE: rtl/fir_q15_if.sv
// ----------------------------------------------------------------------------
// fir_q15 stream interfaces
// Valid/ready channels for the sample beats going in and the filtered
// sample beats coming out.
// ----------------------------------------------------------------------------
interface fir_q15_req_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0]    sample_in;

   modport source (output valid, output sample_in, input ready);
   modport sink   (input valid, input sample_in, output ready);
endinterface

interface fir_q15_rsp_if;
   logic                                       valid;
   logic                                       ready;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0]    sample_out;

   modport source (output valid, output sample_out, input ready);
   modport sink   (input valid, input sample_out, output ready);
endinterface

FILE: rtl/fir_q15_dline.sv
// ----------------------------------------------------------------------------
// fir_q15_dline: circular sample delay line
// Sample memory with one write and one registered read port, a valid bit per
// entry so that unwritten entries read as zero, and the circular write index.
// ----------------------------------------------------------------------------
module fir_q15_dline #(
   parameter int TAPS  = fir_q15_pkg::TAPS_DEFAULT,
   parameter int IDX_W = $clog2(TAPS)
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  fir_q15_pkg::dl_ctrl_type                ctrl,
   input  logic signed [fir_q15_pkg::SAMPLE_W-1:0] wr_data,
   output logic [IDX_W-1:0]                        wr_idx,
   input  logic [IDX_W-1:0]                        rd_addr,
   output logic signed [fir_q15_pkg::SAMPLE_W-1:0] rd_data
);

   logic signed [fir_q15_pkg::SAMPLE_W-1:0] mem_ff [TAPS];
   logic [TAPS-1:0]                         valid_ff;
   logic [TAPS-1:0]                         valid_in;
   logic [IDX_W-1:0]                        wr_idx_ff;
   logic [IDX_W-1:0]                        wr_idx_in;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic                                    rd_vld_ff;

   always_comb begin
      valid_in  = valid_ff;
      wr_idx_in = wr_idx_ff;
      if (ctrl.write) begin
         valid_in[wr_idx_ff] = 1'b1;
      end
      if (ctrl.advance) begin
         if (wr_idx_ff == IDX_W'(TAPS - 1)) begin
            wr_idx_in = '0;
         end else begin
            wr_idx_in = wr_idx_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         wr_idx_ff <= '0;
      end else begin
         valid_ff  <= valid_in;
         wr_idx_ff <= wr_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.write) begin
         mem_ff[wr_idx_ff] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   // The valid flag is sampled together with the data it qualifies.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= valid_ff[rd_addr];
      end
   end

   assign wr_idx  = wr_idx_ff;
   assign rd_data = rd_vld_ff ? rd_data_ff : '0;

endmodule

FILE: rtl/fir_q15_mac.sv
// ----------------------------------------------------------------------------
// fir_q15_mac: digit-serial multiply-accumulate unit
// Multiplies a coefficient by a sample one four-bit digit per cycle, most
// significant digit first, then adds the doubled product into a saturating
// 32-bit accumulator. Also performs the final rounding addition.
// ----------------------------------------------------------------------------
module fir_q15_mac (
   input  logic                                    clock,
   input  fir_q15_pkg::mac_ctrl_type               ctrl,
   input  logic signed [fir_q15_pkg::SAMPLE_W-1:0] coef,
   input  logic signed [fir_q15_pkg::SAMPLE_W-1:0] sample,
   output logic signed [fir_q15_pkg::SAMPLE_W-1:0] result
);

   localparam int PP_W  = fir_q15_pkg::SAMPLE_W + fir_q15_pkg::DIGIT_W + 1;
   localparam int SUM_W = fir_q15_pkg::ACC_W + 2;

   logic signed [fir_q15_pkg::SAMPLE_W-1:0] coef_ff;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] coef_in;
   logic [fir_q15_pkg::SAMPLE_W-1:0]        shift_ff;
   logic [fir_q15_pkg::SAMPLE_W-1:0]        shift_in;
   logic signed [fir_q15_pkg::ACC_W-1:0]    prod_ff;
   logic signed [fir_q15_pkg::ACC_W-1:0]    prod_in;
   logic signed [fir_q15_pkg::ACC_W-1:0]    acc_ff;
   logic signed [fir_q15_pkg::ACC_W-1:0]    acc_in;
   logic [fir_q15_pkg::DIGIT_W-1:0]         digit;
   logic signed [fir_q15_pkg::DIGIT_W:0]    digit_s;
   logic signed [PP_W-1:0]                  pp;
   logic signed [SUM_W-1:0]                 addend;
   logic signed [SUM_W-1:0]                 sum;

   // Clamp a widened sum back into the signed 32-bit range.
   function automatic logic signed [fir_q15_pkg::ACC_W-1:0] sat32(
      input logic signed [SUM_W-1:0] v
   );
      logic signed [fir_q15_pkg::ACC_W-1:0] r;
      r = v[fir_q15_pkg::ACC_W-1:0];
      if (v[SUM_W-1:fir_q15_pkg::ACC_W-1] != '0 && v[SUM_W-1:fir_q15_pkg::ACC_W-1] != '1) begin
         r = v[SUM_W-1] ? {1'b1, {(fir_q15_pkg::ACC_W-1){1'b0}}}
                        : {1'b0, {(fir_q15_pkg::ACC_W-1){1'b1}}};
      end
      return r;
   endfunction

   // The top digit carries the sign of the sample; the others are unsigned.
   assign digit   = shift_ff[fir_q15_pkg::SAMPLE_W-1 -: fir_q15_pkg::DIGIT_W];
   assign digit_s = ctrl.first ? {digit[fir_q15_pkg::DIGIT_W-1], digit} : {1'b0, digit};
   assign pp      = coef_ff * digit_s;

   // Only one of the two addends is in use in a given cycle.
   always_comb begin
      if (ctrl.round) begin
         addend = SUM_W'(fir_q15_pkg::RND_ADD);
      end else begin
         addend = {prod_ff[fir_q15_pkg::ACC_W-1], prod_ff, 1'b0};
      end
      sum = {{2{acc_ff[fir_q15_pkg::ACC_W-1]}}, acc_ff} + addend;
   end

   always_comb begin
      coef_in  = coef_ff;
      shift_in = shift_ff;
      prod_in  = prod_ff;
      acc_in   = acc_ff;
      if (ctrl.start) begin
         coef_in  = coef;
         shift_in = sample;
         prod_in  = '0;
      end else if (ctrl.step) begin
         shift_in = shift_ff << fir_q15_pkg::DIGIT_W;
         prod_in  = (prod_ff <<< fir_q15_pkg::DIGIT_W)
                  + {{(fir_q15_pkg::ACC_W-PP_W){pp[PP_W-1]}}, pp};
      end
      if (ctrl.init) begin
         acc_in = fir_q15_pkg::ACC_INIT;
      end else if (ctrl.accum || ctrl.round) begin
         acc_in = sat32(sum);
      end
   end

   always_ff @(posedge clock) begin
      coef_ff  <= coef_in;
      shift_ff <= shift_in;
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
   end

   assign result = acc_ff[fir_q15_pkg::ACC_W-1 -: fir_q15_pkg::SAMPLE_W];

endmodule

FILE: rtl/fir_filter_q15_circular.sv
// A result beat is offered once each tap has run fetch, load, digit-serial
// multiply and saturating add and the sum has been rounded. One sample is
// worked on at a time: a new sample beat is taken only after the result has
// entered the output register.
// Reset (synchronous, active high) empties the delay line through its valid
// bits at once, zeroes the write index and selects the lowpass set.
// ----------------------------------------------------------------------------
// fir_filter_q15_circular: forty-tap Q15 FIR filter, circular delay line
// Top level: sequencer, filter select register and output register around
// the delay line and the digit-serial multiply-accumulate unit.
// ----------------------------------------------------------------------------
module fir_filter_q15_circular #(
   parameter int TAPS = fir_q15_pkg::TAPS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   fir_q15_req_if.sink       req_bus,
   fir_q15_rsp_if.source     rsp_bus,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);

   localparam int IDX_W = $clog2(TAPS);

   // Sequencer state. A sample beat is taken only in IDLE. Each tap then runs
   // FETCH (memory read issued), LOAD (coefficient and sample into the MAC),
   // MUL (one sample digit per cycle) and ACC (saturating add). ROUND adds the
   // rounding constant, and DONE hands the result to the output register.
   fir_q15_pkg::state_type                  state_ff;
   fir_q15_pkg::state_type                  state_in;

   logic [IDX_W-1:0]                        tap_ff;
   logic [IDX_W-1:0]                        tap_in;
   logic [IDX_W-1:0]                        pos_ff;
   logic [IDX_W-1:0]                        pos_in;
   logic [fir_q15_pkg::DIGIT_CNT_W-1:0]     dig_cnt_ff;
   logic [fir_q15_pkg::DIGIT_CNT_W-1:0]     dig_cnt_in;
   logic                                    filter_sel_ff;
   logic                                    rsp_valid_ff;
   logic                                    rsp_valid_in;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] sample_out_ff;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] sample_out_in;

   fir_q15_pkg::mac_ctrl_type               mac_ctrl;
   fir_q15_pkg::dl_ctrl_type                dl_ctrl;
   logic [IDX_W-1:0]                        wr_idx;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] rd_sample;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] coef;
   logic signed [fir_q15_pkg::SAMPLE_W-1:0] mac_result;
   logic                                    in_beat;
   logic                                    out_free;
   logic                                    last_tap;
   logic                                    last_digit;

   assign in_beat    = req_bus.valid && req_bus.ready;
   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign last_tap   = (tap_ff == IDX_W'(TAPS - 1));
   assign last_digit = (dig_cnt_ff == fir_q15_pkg::DIGIT_CNT_W'(fir_q15_pkg::DIGITS - 1));

   // Coefficients are looked up by tap number, newest sample first.
   assign coef = fir_q15_pkg::coef_at(filter_sel_ff, fir_q15_pkg::TAP_IDX_W'(tap_ff));

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fir_q15_pkg::ST_IDLE: begin
            if (req_bus.valid) begin
               state_in = fir_q15_pkg::ST_FETCH;
            end
         end
         fir_q15_pkg::ST_FETCH: state_in = fir_q15_pkg::ST_LOAD;
         fir_q15_pkg::ST_LOAD:  state_in = fir_q15_pkg::ST_MUL;
         fir_q15_pkg::ST_MUL: begin
            if (last_digit) begin
               state_in = fir_q15_pkg::ST_ACC;
            end
         end
         fir_q15_pkg::ST_ACC: begin
            if (last_tap) begin
               state_in = fir_q15_pkg::ST_ROUND;
            end else begin
               state_in = fir_q15_pkg::ST_FETCH;
            end
         end
         fir_q15_pkg::ST_ROUND: state_in = fir_q15_pkg::ST_DONE;
         fir_q15_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = fir_q15_pkg::ST_IDLE;
            end
         end
         default: state_in = fir_q15_pkg::ST_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_bus.ready = 1'b0;
      mac_ctrl      = '0;
      dl_ctrl       = '0;
      tap_in        = tap_ff;
      pos_in        = pos_ff;
      dig_cnt_in    = dig_cnt_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      sample_out_in = sample_out_ff;
      unique case (state_ff)
         fir_q15_pkg::ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (in_beat) begin
               dl_ctrl.write = 1'b1;
               mac_ctrl.init = 1'b1;
               tap_in        = '0;
               pos_in        = wr_idx;
            end
         end
         fir_q15_pkg::ST_FETCH: begin
            // The read address is pos_ff; data arrives for LOAD.
         end
         fir_q15_pkg::ST_LOAD: begin
            mac_ctrl.start = 1'b1;
            dig_cnt_in     = '0;
         end
         fir_q15_pkg::ST_MUL: begin
            mac_ctrl.step  = 1'b1;
            mac_ctrl.first = (dig_cnt_ff == '0);
            dig_cnt_in     = dig_cnt_ff + fir_q15_pkg::DIGIT_CNT_W'(1);
         end
         fir_q15_pkg::ST_ACC: begin
            mac_ctrl.accum = 1'b1;
            tap_in         = tap_ff + IDX_W'(1);
            // Walk backward through the circular buffer toward older samples.
            if (pos_ff == '0) begin
               pos_in = IDX_W'(TAPS - 1);
            end else begin
               pos_in = pos_ff - IDX_W'(1);
            end
         end
         fir_q15_pkg::ST_ROUND: begin
            mac_ctrl.round  = 1'b1;
            dl_ctrl.advance = 1'b1;
         end
         fir_q15_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               sample_out_in = mac_result;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= fir_q15_pkg::ST_IDLE;
         filter_sel_ff <= fir_q15_pkg::FILTER_LOWPASS;
         rsp_valid_ff  <= 1'b0;
         tap_ff        <= '0;
         pos_ff        <= '0;
         dig_cnt_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         tap_ff       <= tap_in;
         pos_ff       <= pos_in;
         dig_cnt_ff   <= dig_cnt_in;
         if (csr_wr_en) begin
            filter_sel_ff <= csr_wr_data;
         end
      end
   end

   // The output holding register needs no reset; valid qualifies it.
   always_ff @(posedge clock) begin
      sample_out_ff <= sample_out_in;
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.sample_out = sample_out_ff;

   fir_q15_dline #(
      .TAPS  (TAPS),
      .IDX_W (IDX_W)
   ) u_dline (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (dl_ctrl),
      .wr_data (req_bus.sample_in),
      .wr_idx  (wr_idx),
      .rd_addr (pos_ff),
      .rd_data (rd_sample)
   );

   fir_q15_mac u_mac (
      .clock  (clock),
      .ctrl   (mac_ctrl),
      .coef   (coef),
      .sample (rd_sample),
      .result (mac_result)
   );

endmodule

FILE: rtl/fir_q15_checker.sv
// ----------------------------------------------------------------------------
// fir_q15_checker: port-level checks for the Q15 FIR filter
// Watches the stream ports of the top level over time.
// ----------------------------------------------------------------------------
module fir_q15_checker (
   input logic                                    clock,
   input logic                                    reset,
   input logic                                    req_valid,
   input logic                                    req_ready,
   input logic                                    rsp_valid,
   input logic                                    rsp_ready,
   input logic signed [fir_q15_pkg::SAMPLE_W-1:0] sample_out
);

   // A result beat held back by the sink keeps its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(sample_out)))
      else $error("stalled result beat changed");

   // Reset leaves no result pending.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // The block works on one sample at a time.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("second sample taken while the first is in work");

   // A new result only appears at the end of a computation.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while idle");

endmodule

bind fir_filter_q15_circular fir_q15_checker u_fir_q15_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_bus.valid),
   .req_ready  (req_bus.ready),
   .rsp_valid  (rsp_bus.valid),
   .rsp_ready  (rsp_bus.ready),
   .sample_out (rsp_bus.sample_out)
);
